>>> src/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types, constants and helpers for the keypad combination lock.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

    localparam int CODE_LENGTH = 4;
    localparam int POS_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    localparam logic [7:0] KEY_NONE = 8'h00;
    localparam logic [7:0] KEY_HASH = 8'h23;
    localparam logic [7:0] KEY_STAR = 8'h2A;

    localparam logic [7:0] TIMEOUT_RESET = 8'd40;

    // register indexes
    localparam logic REG_INITIAL_CODE  = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    typedef enum logic [2:0] {
        E_IDLE,
        E_WAIT_REL,
        E_WAIT,
        E_GET,
        E_FAIL_REL,
        E_OK_REL,
        E_UNLOCK
    } t_entry_phase;

    typedef enum logic {
        D_LOCKED,
        D_UNLOCKED
    } t_display_phase;

    typedef enum logic [3:0] {
        P_START,
        P_WAIT,
        P_ASSIGN,
        P_OK_REL,
        P_FAIL_REL,
        P_WAIT_END,
        P_WAIT_CHECK,
        P_CHECK,
        P_OK_CHECK_REL
    } t_program_phase;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [7:0]       t_key;

    // configuration request toward the core
    typedef struct packed {
        logic        code_load;
        logic [31:0] code;
        logic [7:0]  timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic is_locked;
        logic lock_indicator;
        logic code_changed;
    } t_result;

    function automatic t_pos slot(input t_pos i);
        return (32'(i) < CODE_LENGTH) ? i : '0;
    endfunction

endpackage

`default_nettype wire

>>> src/kcl_core.sv
// ----------------------------------------------------------------------------
// kcl_core
// Entry, lock/display and programming machines; one step per request.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_core
    import kcl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire logic    i_step,
    input  wire t_key    i_key_first,
    input  wire t_key    i_key_second,
    input  wire logic    i_lock_button,
    output t_result      o_result
);

    t_entry_phase   r_entry, n_entry;
    t_pos           r_epos, n_epos;
    t_display_phase r_disp, n_disp;
    logic           r_locked, n_locked;
    t_program_phase r_prog, n_prog;
    t_pos           r_pidx, n_pidx;
    logic [7:0]     r_conf, n_conf;
    t_key           r_cand [CODE_LENGTH];
    t_key           r_stored [CODE_LENGTH];
    logic           n_changed;
    logic           none;
    t_entry_phase   e_mid;
    logic           l_mid;

    assign none = (i_key_first == KEY_NONE) && (i_key_second == KEY_NONE);

    // entry and lock/display machines
    always_comb begin
        e_mid  = r_entry;
        n_epos = r_epos;
        case (r_entry)
            E_IDLE: begin
                if (i_key_first == KEY_HASH) begin
                    n_epos = '0;
                    e_mid  = E_WAIT_REL;
                end
            end
            E_WAIT_REL: if (i_key_first == KEY_NONE) e_mid = E_WAIT;
            E_WAIT:     if (i_key_first != KEY_NONE) e_mid = E_GET;
            E_GET: begin
                e_mid = (i_key_first == r_stored[slot(r_epos)]) ? E_OK_REL : E_FAIL_REL;
            end
            E_FAIL_REL: if (i_key_first == KEY_NONE) e_mid = E_IDLE;
            E_OK_REL: begin
                if (i_key_first == KEY_NONE) begin
                    if (r_epos >= t_pos'(CODE_LENGTH - 1)) begin
                        e_mid = E_UNLOCK;
                    end else begin
                        e_mid  = E_WAIT;
                        n_epos = r_epos + t_pos'(1);
                    end
                end
            end
            default: e_mid = E_IDLE;
        endcase
        n_entry = e_mid;
        l_mid   = (e_mid == E_UNLOCK) ? 1'b0 : r_locked;

        n_disp   = r_disp;
        n_locked = l_mid;
        if (r_disp == D_LOCKED) begin
            if (!l_mid) n_disp = D_UNLOCKED;
        end else if (i_lock_button) begin
            n_disp   = D_LOCKED;
            n_locked = 1'b1;
        end
    end

    // programming machine
    always_comb begin
        n_prog    = r_prog;
        n_pidx    = r_pidx;
        n_conf    = r_conf;
        n_changed = 1'b0;
        case (r_prog)
            P_START: begin
                if (i_key_first == KEY_STAR && i_lock_button) begin
                    n_pidx = '0;
                    n_prog = P_WAIT;
                end
            end
            P_WAIT: begin
                if (!i_lock_button ||
                    !(i_key_first == KEY_STAR || i_key_second == KEY_STAR)) begin
                    n_prog = P_FAIL_REL;
                end else if (i_key_first != KEY_NONE && i_key_second != KEY_NONE) begin
                    n_prog = P_ASSIGN;
                end
            end
            P_ASSIGN: n_prog = P_OK_REL;
            P_OK_REL: begin
                if (i_key_first == KEY_NONE || i_key_second == KEY_NONE) begin
                    if (r_pidx >= t_pos'(CODE_LENGTH - 1)) begin
                        n_prog = P_WAIT_END;
                    end else begin
                        n_prog = P_WAIT;
                        n_pidx = r_pidx + t_pos'(1);
                    end
                end
            end
            P_WAIT_END: begin
                if (none && !i_lock_button) begin
                    n_prog = P_WAIT_CHECK;
                    n_conf = '0;
                    n_pidx = '0;
                end
            end
            P_WAIT_CHECK: if (i_key_first != KEY_NONE) n_prog = P_CHECK;
            P_CHECK: begin
                if (i_key_first != r_cand[slot(r_pidx)] || r_conf > i_cfg.timeout_ticks) begin
                    n_prog = P_FAIL_REL;
                end else begin
                    n_prog = P_OK_CHECK_REL;
                end
            end
            P_FAIL_REL: if (none) n_prog = P_START;
            P_OK_CHECK_REL: begin
                if (r_pidx >= t_pos'(CODE_LENGTH - 1)) begin
                    n_prog    = P_START;
                    n_changed = 1'b1;
                end else if (none) begin
                    n_prog = P_WAIT_CHECK;
                    n_pidx = r_pidx + t_pos'(1);
                end
            end
            default: n_prog = P_START;
        endcase
        // count confirmation ticks, saturate at full scale
        if ((n_prog == P_WAIT_CHECK || n_prog == P_CHECK || n_prog == P_OK_CHECK_REL) &&
            n_conf != 8'hFF) begin
            n_conf = n_conf + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry  <= E_IDLE;
            r_epos   <= '0;
            r_disp   <= D_LOCKED;
            r_locked <= 1'b1;
            r_prog   <= P_START;
            r_pidx   <= '0;
            r_conf   <= '0;
            for (int k = 0; k < CODE_LENGTH; k++) begin
                r_cand[k]   <= '0;
                r_stored[k] <= '0;
            end
        end else if (i_step) begin
            r_entry  <= n_entry;
            r_epos   <= n_epos;
            r_disp   <= n_disp;
            r_locked <= n_locked;
            r_prog   <= n_prog;
            r_pidx   <= n_pidx;
            r_conf   <= n_conf;
            if (n_prog == P_ASSIGN) begin
                r_cand[slot(n_pidx)] <= (i_key_first == KEY_STAR) ? i_key_second : i_key_first;
            end
            if (n_changed) begin
                for (int k = 0; k < CODE_LENGTH; k++) r_stored[k] <= r_cand[k];
            end
        end else if (i_cfg.code_load) begin
            for (int k = 0; k < CODE_LENGTH; k++) begin
                r_stored[k] <= 8'(i_cfg.code >> (8 * k));
            end
        end
    end

    assign o_result.is_locked      = n_locked;
    assign o_result.lock_indicator = (n_disp == D_LOCKED);
    assign o_result.code_changed   = n_changed;

endmodule

`default_nettype wire

>>> src/keypad_combination_lock_top.sv
// An accepted request passes through the input register, then the result register.
// Throughput: one request per cycle; the input register and the result
// register form a two-stage pipeline that stalls only on m_axis_tready.
// Reset (synchronous, active low): door locked, all machines idle, stored
// combination zero, timeout 40 ticks.
// ----------------------------------------------------------------------------
// keypad_combination_lock_top
// Keypad door lock: stream of key ticks in, lock status out, APB setup.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_combination_lock_top
    import kcl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [7:0] key_first, [15:8] key_second,
                                            // [16] lock_button, [23:17] zero
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata   // [0] is_locked, [1] lock_indicator,
                                            // [2] code_changed, [7:3] zero
);

    logic [31:0] r_initial_code;
    logic [7:0]  r_timeout;
    logic        wr;
    t_cfg        cfg;

    logic        r_in_valid;
    t_key        r_key_first;
    t_key        r_key_second;
    logic        r_button;
    logic        r_out_valid;
    t_result     r_out;
    t_result     step_result;
    logic        advance;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_code <= '0;
            r_timeout      <= TIMEOUT_RESET;
        end else if (wr) begin
            case (paddr[2])
                REG_INITIAL_CODE:  r_initial_code <= pwdata;
                REG_TIMEOUT_TICKS: r_timeout      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_INITIAL_CODE:  prdata = r_initial_code;
            REG_TIMEOUT_TICKS: prdata = {24'd0, r_timeout};
            default:           prdata = '0;
        endcase
    end

    assign cfg.code_load     = wr && (paddr[2] == REG_INITIAL_CODE);
    assign cfg.code          = pwdata;
    assign cfg.timeout_ticks = r_timeout;

    // pipeline: input register -> step logic -> result register
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_key_first  <= s_axis_tdata[7:0];
            r_key_second <= s_axis_tdata[15:8];
            r_button     <= s_axis_tdata[16];
        end
        if (advance) r_out <= step_result;
    end

    kcl_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_step        (advance),
        .i_key_first   (r_key_first),
        .i_key_second  (r_key_second),
        .i_lock_button (r_button),
        .o_result      (step_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.code_changed, r_out.lock_indicator, r_out.is_locked};

endmodule

`default_nettype wire

>>> dv/keypad_combination_lock_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_combination_lock_top_test
// Self-checking bench for the keypad lock. Key ticks go in as stream
// requests and a cycle-level predictor of the entry, lock and programming
// machines builds the expected lock status for every accepted request.
// Unlock attempts, lock presses, code programming (good, wrong, late,
// aborted) and noise run under several register settings and idle patterns.
// ----------------------------------------------------------------------------

module keypad_combination_lock_top_test;

    import kcl_pkg::*;

    localparam logic [2:0] ADDR_INITIAL_CODE  = {REG_INITIAL_CODE, 2'b00};
    localparam logic [2:0] ADDR_TIMEOUT_TICKS = {REG_TIMEOUT_TICKS, 2'b00};

    typedef enum {
        PROG_CONFIRM_OK,
        PROG_CONFIRM_WRONG,
        PROG_CONFIRM_LATE,
        PROG_ABORT
    } t_prog_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;  // [7:0] key_first, [15:8] key_second,
                                      // [16] lock_button, [23:17] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [0] is_locked, [1] lock_indicator,
                                      // [2] code_changed, [7:3] zero

    keypad_combination_lock_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // lock state mirror
    t_entry_phase   entry_st;
    t_pos           entry_pos;
    t_display_phase display_st;
    logic           door_locked;
    t_program_phase prog_st;
    t_pos           prog_pos;
    t_key           candidate_combo [CODE_LENGTH];
    t_key           stored_combo [CODE_LENGTH];
    logic [7:0]     confirm_count;
    logic [7:0]     cfg_timeout;

    t_result expected_status_q [$];
    int      mismatch_count = 0;
    int      items_sent     = 0;
    int      send_idle_pct  = 33;
    int      recv_idle_pct  = 57;

    task automatic clear_lock_state();
        entry_st      = E_IDLE;
        entry_pos     = '0;
        display_st    = D_LOCKED;
        door_locked   = 1'b1;
        prog_st       = P_START;
        prog_pos      = '0;
        confirm_count = '0;
        cfg_timeout   = TIMEOUT_RESET;
        for (int k = 0; k < CODE_LENGTH; k++) begin
            candidate_combo[k] = '0;
            stored_combo[k]    = '0;
        end
    endtask

    // Advance all three machines by one tick; entry sees the old combination.
    function automatic t_result lock_status_after_tick(input t_key k0, input t_key k1,
                                                       input logic button);
        t_result status;
        logic    no_keys;
        no_keys             = (k0 == KEY_NONE) && (k1 == KEY_NONE);
        status.code_changed = 1'b0;

        case (entry_st)
            E_IDLE: begin
                if (k0 == KEY_HASH) begin
                    entry_pos = '0;
                    entry_st  = E_WAIT_REL;
                end
            end
            E_WAIT_REL: if (k0 == KEY_NONE) entry_st = E_WAIT;
            E_WAIT:     if (k0 != KEY_NONE) entry_st = E_GET;
            E_GET:      entry_st = (k0 == stored_combo[entry_pos]) ? E_OK_REL : E_FAIL_REL;
            E_FAIL_REL: if (k0 == KEY_NONE) entry_st = E_IDLE;
            E_OK_REL: begin
                if (k0 == KEY_NONE) begin
                    if (32'(entry_pos) >= CODE_LENGTH - 1) begin
                        entry_st = E_UNLOCK;
                    end else begin
                        entry_st  = E_WAIT;
                        entry_pos = entry_pos + 1'b1;
                    end
                end
            end
            default: entry_st = E_IDLE;
        endcase
        if (entry_st == E_UNLOCK) door_locked = 1'b0;

        if (display_st == D_LOCKED) begin
            if (!door_locked) display_st = D_UNLOCKED;
        end else if (button) begin
            display_st  = D_LOCKED;
            door_locked = 1'b1;
        end

        case (prog_st)
            P_START: begin
                if (k0 == KEY_STAR && button) begin
                    prog_pos = '0;
                    prog_st  = P_WAIT;
                end
            end
            P_WAIT: begin
                if (!button || !(k0 == KEY_STAR || k1 == KEY_STAR)) prog_st = P_FAIL_REL;
                else if (k0 != KEY_NONE && k1 != KEY_NONE) prog_st = P_ASSIGN;
            end
            P_ASSIGN: prog_st = P_OK_REL;
            P_OK_REL: begin
                if (k0 == KEY_NONE || k1 == KEY_NONE) begin
                    if (32'(prog_pos) >= CODE_LENGTH - 1) begin
                        prog_st = P_WAIT_END;
                    end else begin
                        prog_st  = P_WAIT;
                        prog_pos = prog_pos + 1'b1;
                    end
                end
            end
            P_WAIT_END: begin
                if (no_keys && !button) begin
                    prog_st       = P_WAIT_CHECK;
                    confirm_count = '0;
                    prog_pos      = '0;
                end
            end
            P_WAIT_CHECK: if (k0 != KEY_NONE) prog_st = P_CHECK;
            P_CHECK: begin
                if (k0 != candidate_combo[prog_pos] || confirm_count > cfg_timeout)
                    prog_st = P_FAIL_REL;
                else
                    prog_st = P_OK_CHECK_REL;
            end
            P_FAIL_REL: if (no_keys) prog_st = P_START;
            P_OK_CHECK_REL: begin
                // last confirmation key commits without waiting for release
                if (32'(prog_pos) >= CODE_LENGTH - 1) begin
                    prog_st = P_START;
                    for (int k = 0; k < CODE_LENGTH; k++) stored_combo[k] = candidate_combo[k];
                    status.code_changed = 1'b1;
                end else if (no_keys) begin
                    prog_st  = P_WAIT_CHECK;
                    prog_pos = prog_pos + 1'b1;
                end
            end
            default: prog_st = P_START;
        endcase

        case (prog_st)
            P_ASSIGN: candidate_combo[prog_pos] = (k0 == KEY_STAR) ? k1 : k0;
            P_WAIT_CHECK, P_CHECK, P_OK_CHECK_REL: begin
                if (confirm_count < 8'd255) confirm_count = confirm_count + 1'b1;
            end
            default: ;
        endcase

        status.is_locked      = door_locked;
        status.lock_indicator = (display_st == D_LOCKED);
        return status;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_tick(input t_key k0, input t_key k1, input logic button);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, button, k1, k0};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_status_q.push_back(lock_status_after_tick(k0, k1, button));
        items_sent++;
    endtask

    task automatic send_hold(input t_key k0, input t_key k1, input logic button,
                             input int count);
        repeat (count) send_tick(k0, k1, button);
    endtask

    // Hold requests until every expected status is back and the pipe is empty.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_initial_code(input logic [31:0] code);
        apb_write(ADDR_INITIAL_CODE, code);
        for (int k = 0; k < CODE_LENGTH; k++)
            stored_combo[k] = (k < 4) ? code[8*k +: 8] : '0;
    endtask

    task automatic set_timeout(input logic [7:0] ticks);
        apb_write(ADDR_TIMEOUT_TICKS, {24'b0, ticks});
        cfg_timeout = ticks;
    endtask

    function automatic logic [31:0] random_nonzero_code();
        return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
    endfunction

    // ------------------------------------------------------------------------
    // result check
    // ------------------------------------------------------------------------
    task automatic check_bit(input string field, input logic want, input logic got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_status_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: status expected none actual %b", $time, m_axis_tdata);
            end else begin
                want = expected_status_q.pop_front();
                check_bit("is_locked", want.is_locked, m_axis_tdata[0]);
                check_bit("lock_indicator", want.lock_indicator, m_axis_tdata[1]);
                check_bit("code_changed", want.code_changed, m_axis_tdata[2]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // request sequences
    // ------------------------------------------------------------------------
    task automatic try_unlock(input bit right_code);
        int   wrong_pos;
        t_key key;
        send_hold(KEY_NONE, KEY_NONE, 1'b0, $urandom_range(1, 2));
        wrong_pos = right_code ? CODE_LENGTH : $urandom_range(CODE_LENGTH - 1);
        send_hold(KEY_HASH, t_key'($urandom_range(255)), 1'b0, $urandom_range(1, 2));
        send_hold(KEY_NONE, KEY_NONE, 1'b0, $urandom_range(1, 2));
        for (int i = 0; i < CODE_LENGTH; i++) begin
            key = stored_combo[i];
            if (i == wrong_pos) key = key ^ t_key'($urandom_range(1, 255));
            if (key == KEY_NONE) begin
                // any key starts the compare, the release then matches a zero key
                send_tick(t_key'($urandom_range(1, 255)), KEY_NONE, 1'b0);
                send_hold(KEY_NONE, KEY_NONE, 1'b0, $urandom_range(2, 3));
            end else begin
                send_hold(key, ($urandom_range(3) == 0) ? t_key'($urandom_range(255)) : KEY_NONE,
                          1'b0, $urandom_range(2, 3));
                send_hold(KEY_NONE, KEY_NONE, 1'b0, $urandom_range(1, 2));
            end
        end
    endtask

    task automatic press_lock_button();
        send_hold(KEY_NONE, KEY_NONE, 1'b1, $urandom_range(1, 3));
    endtask

    task automatic program_new_code(input t_prog_mode mode);
        t_key new_combo [CODE_LENGTH];
        t_key key;
        int   wrong_pos;
        int   gap;
        bit   star_first;
        send_hold(KEY_NONE, KEY_NONE, 1'b0, $urandom_range(1, 2));
        send_hold(KEY_STAR, KEY_NONE, 1'b1, $urandom_range(1, 2));
        for (int i = 0; i < CODE_LENGTH; i++) begin
            new_combo[i] = t_key'($urandom_range(1, 255));
            star_first   = $urandom_range(1);
            if (mode == PROG_ABORT && i == 2) begin
                send_hold(KEY_NONE, KEY_NONE, 1'b0, 2);
                return;
            end
            if (star_first) begin
                send_hold(KEY_STAR, new_combo[i], 1'b1, $urandom_range(2, 3));
                send_hold(KEY_STAR, KEY_NONE, 1'b1, $urandom_range(1, 2));
            end else begin
                send_hold(new_combo[i], KEY_STAR, 1'b1, $urandom_range(2, 3));
                send_hold(KEY_NONE, KEY_STAR, 1'b1, $urandom_range(1, 2));
            end
        end
        send_hold(KEY_NONE, KEY_NONE, 1'b0, $urandom_range(1, 2));

        wrong_pos = (mode == PROG_CONFIRM_WRONG) ? $urandom_range(CODE_LENGTH - 1) : CODE_LENGTH;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            gap = $urandom_range(1);
            // land the first confirmation around the timeout boundary
            if (mode == PROG_CONFIRM_LATE && i == 0) begin
                gap = int'(cfg_timeout) - 3 + $urandom_range(3);
                if (gap < 0) gap = 0;
            end
            send_hold(KEY_NONE, KEY_NONE, 1'b0, gap);
            key = new_combo[i];
            if (i == wrong_pos) begin
                key = key ^ t_key'($urandom_range(1, 255));
                if (key == KEY_NONE) key = (new_combo[i] == 8'hFF) ? 8'h01 : 8'hFF;
            end
            send_hold(key, KEY_NONE, 1'b0, $urandom_range(2, 3));
            send_hold(KEY_NONE, KEY_NONE, 1'b0, $urandom_range(1, 2));
        end
    endtask

    task automatic send_noise_burst();
        t_key k0;
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(3))
                0:       k0 = KEY_NONE;
                1:       k0 = KEY_HASH;
                2:       k0 = KEY_STAR;
                default: k0 = t_key'($urandom_range(255));
            endcase
            send_tick(k0, $urandom_range(1) ? t_key'($urandom_range(255)) : KEY_NONE,
                      1'($urandom_range(1)));
        end
    endtask

    task automatic apply_setting(input int sel);
        case (sel)
            0: begin
                set_initial_code(32'h0000_0000);
                set_timeout(8'd0);
            end
            1: begin
                set_initial_code(32'hFFFF_FFFF);
                set_timeout(8'd255);
            end
            3: begin
                set_initial_code($urandom);
                set_timeout(TIMEOUT_RESET);
            end
            4: begin
                set_initial_code(random_nonzero_code());
                set_timeout(8'($urandom_range(255)));
            end
            default: begin
                set_initial_code(random_nonzero_code());
                set_timeout(8'($urandom_range(2, 20)));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_unlock_relock();
        logic [31:0] code;
        code = 32'h3433_3231;  // '1' '2' '3' '4'
        set_initial_code(code);
        send_tick(KEY_HASH, KEY_NONE, 1'b0);
        send_tick(KEY_NONE, KEY_NONE, 1'b0);
        for (int i = 0; i < CODE_LENGTH; i++) begin
            send_hold(code[8*i +: 8], KEY_NONE, 1'b0, 2);
            send_tick(KEY_NONE, KEY_NONE, 1'b0);
        end
        send_tick(KEY_NONE, KEY_NONE, 1'b1);
    endtask

    task automatic test_field_extremes();
        send_tick(8'hFF, 8'hFF, 1'b1);
        send_tick(KEY_NONE, KEY_NONE, 1'b0);
        send_tick(8'hFF, KEY_NONE, 1'b0);
        send_tick(KEY_NONE, 8'hFF, 1'b1);
        send_tick(8'hAA, 8'h55, 1'b0);
        send_tick(8'h55, 8'hAA, 1'b1);
    endtask

    task automatic test_code_programming();
        wait_results_drained();
        set_initial_code(random_nonzero_code());
        set_timeout(8'd255);
        program_new_code(PROG_CONFIRM_OK);
        // confirmation counter saturates and never exceeds the widest window
        program_new_code(PROG_CONFIRM_LATE);
        try_unlock(1'b1);
        press_lock_button();
        wait_results_drained();
        set_timeout(8'd0);
        program_new_code(PROG_CONFIRM_LATE);
        program_new_code(PROG_CONFIRM_WRONG);
        program_new_code(PROG_ABORT);
        wait_results_drained();
        set_timeout(TIMEOUT_RESET);
        program_new_code(PROG_CONFIRM_OK);
        try_unlock(1'b1);
        press_lock_button();
        try_unlock(1'b0);
    endtask

    task automatic test_mixed_traffic(input int sender_pct, input int receiver_pct,
                                      input int first_setting);
        int goal;
        int pick;
        int mode_pick;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int half = 0; half < 2; half++) begin
            wait_results_drained();
            apply_setting(first_setting + half);
            goal = items_sent + 70;
            while (items_sent < goal) begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    try_unlock(pick < 28);
                end else if (pick < 45) begin
                    press_lock_button();
                end else if (pick < 75) begin
                    mode_pick = $urandom_range(3);
                    if (mode_pick == 2 && cfg_timeout > 8'd60) mode_pick = 0;
                    case (mode_pick)
                        0:       program_new_code(PROG_CONFIRM_OK);
                        1:       program_new_code(PROG_CONFIRM_WRONG);
                        2:       program_new_code(PROG_CONFIRM_LATE);
                        default: program_new_code(PROG_ABORT);
                    endcase
                end else begin
                    send_noise_burst();
                end
                if ($urandom_range(99) < 4) wait_results_drained();
            end
        end
    endtask

    initial begin
        clear_lock_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unlock_relock();
        test_field_extremes();
        test_code_programming();
        test_mixed_traffic(33, 57, 0);
        test_mixed_traffic(57, 33, 2);
        test_mixed_traffic(0, 0, 4);

        wait_results_drained();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
